/* design/bpra_pkg.sv */
// ---------------------------------------------------------------------------
// bpra_pkg
// Shared types, codes and helpers of the bitmap page run allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package bpra_pkg;

    localparam int NUM_PAGES = 32;
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    localparam int CNT_W     = 6;
    localparam int START_W   = 5;
    localparam int FIRST_W   = 5;
    localparam int STATUS_W  = 2;
    localparam int SUM_W     = ((PAGE_W > CNT_W) ? PAGE_W : CNT_W) + 1;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_COUNT = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic do_free;
        logic set_zero;
        logic scan;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic op_free;
        logic cnt_zero;
        logic hit;
        logic last_page;
        logic out_busy;
    } dp_status_t;

    // pages first .. first+count-1, clipped at the last page
    function automatic logic [NUM_PAGES-1:0] run_mask(
        input logic [SUM_W-1:0] first,
        input logic [CNT_W-1:0] count
    );
        logic [NUM_PAGES-1:0] mask;
        logic [SUM_W-1:0]     stop;
        stop = first + SUM_W'(count);
        for (int i = 0; i < NUM_PAGES; i++) begin
            mask[i] = (SUM_W'(i) >= first) && (SUM_W'(i) < stop);
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

/* design/bpra_dp.sv */
// ---------------------------------------------------------------------------
// bpra_dp
// Datapath: page bitmap, request latch, first-fit scan and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module bpra_dp (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire bpra_pkg::dp_cmd_t              cmd,
    output bpra_pkg::dp_status_t                stat,
    input  wire logic                           req_op,
    input  wire logic [bpra_pkg::CNT_W-1:0]     req_count,
    input  wire logic [bpra_pkg::START_W-1:0]   req_start,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [bpra_pkg::STATUS_W-1:0]       out_status,
    output logic [bpra_pkg::FIRST_W-1:0]        out_first
);

    logic [bpra_pkg::NUM_PAGES-1:0] map_reg, map_next;
    logic                           op_reg;
    logic [bpra_pkg::CNT_W-1:0]     count_reg;
    logic [bpra_pkg::START_W-1:0]   start_reg;
    logic [bpra_pkg::PAGE_W-1:0]    page_reg;
    logic [bpra_pkg::SUM_W-1:0]     run_reg;
    logic [bpra_pkg::SUM_W-1:0]     run_start_reg;
    logic [bpra_pkg::STATUS_W-1:0]  status_reg;
    logic [bpra_pkg::FIRST_W-1:0]   first_reg;
    logic                           out_valid_reg;
    logic [bpra_pkg::STATUS_W-1:0]  out_status_reg;
    logic [bpra_pkg::FIRST_W-1:0]   out_first_reg;

    logic                           page_used;
    logic [bpra_pkg::SUM_W-1:0]     run_inc;
    logic [bpra_pkg::SUM_W-1:0]     start_now;
    logic                           hit;

    assign page_used = map_reg[page_reg];
    assign run_inc   = run_reg + bpra_pkg::SUM_W'(1);
    assign start_now = (run_reg == '0) ? bpra_pkg::SUM_W'(page_reg) : run_start_reg;
    assign hit       = !page_used && (run_inc == bpra_pkg::SUM_W'(count_reg));

    always_comb begin
        map_next = map_reg;
        if (cmd.do_free) begin
            map_next = map_reg &
                ~bpra_pkg::run_mask(bpra_pkg::SUM_W'(start_reg), count_reg);
        end else if (cmd.scan && hit) begin
            map_next = map_reg | bpra_pkg::run_mask(start_now, count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            map_reg <= map_next;
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg     <= req_op;
            count_reg  <= req_count;
            start_reg  <= req_start;
            page_reg   <= '0;
            run_reg    <= '0;
            status_reg <= bpra_pkg::ST_OK;
            first_reg  <= '0;
        end else if (cmd.set_zero) begin
            status_reg <= bpra_pkg::ST_ZERO_COUNT;
        end else if (cmd.scan) begin
            page_reg <= page_reg + bpra_pkg::PAGE_W'(1);
            if (page_used) begin
                run_reg <= '0;
            end else begin
                run_reg       <= run_inc;
                run_start_reg <= start_now;
            end
            if (hit) begin
                first_reg <= bpra_pkg::FIRST_W'(start_now);
            end else if (page_reg == bpra_pkg::PAGE_W'(bpra_pkg::NUM_PAGES - 1)) begin
                status_reg <= bpra_pkg::ST_NO_SPACE;
            end
        end
        if (cmd.load_out) begin
            out_status_reg <= status_reg;
            out_first_reg  <= first_reg;
        end
    end

    assign stat.op_free   = (op_reg == bpra_pkg::OP_FREE);
    assign stat.cnt_zero  = (count_reg == '0);
    assign stat.hit       = hit;
    assign stat.last_page = (page_reg == bpra_pkg::PAGE_W'(bpra_pkg::NUM_PAGES - 1));
    assign stat.out_busy  = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_first  = out_first_reg;

endmodule

`default_nettype wire

/* design/bpra_ctrl.sv */
// ---------------------------------------------------------------------------
// bpra_ctrl
// Controller: sequences accept, decode, bitmap scan and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module bpra_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire bpra_pkg::dp_status_t  stat,
    output bpra_pkg::dp_cmd_t          cmd
);

    bpra_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bpra_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            bpra_pkg::S_IDLE: begin
                in_ready = aresetn;
                if (in_valid && aresetn) begin
                    cmd.accept = 1'b1;
                    state_next = bpra_pkg::S_DECODE;
                end
            end
            bpra_pkg::S_DECODE: begin
                if (stat.op_free) begin
                    cmd.do_free = 1'b1;
                    state_next  = bpra_pkg::S_DONE;
                end else if (stat.cnt_zero) begin
                    cmd.set_zero = 1'b1;
                    state_next   = bpra_pkg::S_DONE;
                end else begin
                    state_next = bpra_pkg::S_SCAN;
                end
            end
            bpra_pkg::S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.hit || stat.last_page) begin
                    state_next = bpra_pkg::S_DONE;
                end
            end
            bpra_pkg::S_DONE: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = bpra_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bpra_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/bitmap_page_run_allocator.sv */
// ---------------------------------------------------------------------------
// bitmap_page_run_allocator
// First-fit allocator of contiguous page runs over a used/free page bitmap.
//
// Usage:
//   Input item (s_): s_tuser holds the opcode (0 allocate, 1 free); s_tdata
//   holds page_count and start_page. Result item (m_): m_tdata holds status
//   (0 ok, 1 no space, 2 zero count) and first_page.
//   Items are taken one at a time. A free or a zero-count allocate goes
//   from decode straight to the result with no scan. An allocate scans the
//   bitmap one page per cycle from page 0 and stops at the last page of the
//   first run that fits, or after the last page when no run fits.
//   A new item is accepted in the cycle after the result is loaded into
//   the output register, even while that result still waits on m_tready.
//   A stalled receiver holds m_tvalid and m_tdata; once the output register
//   is full and the next result is ready, the block holds until it drains.
//   Reset marks every page free and drops any pending result.
// ---------------------------------------------------------------------------
`default_nettype none

module bitmap_page_run_allocator (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [bpra_pkg::S_TDATA_W-1:0]    s_tdata,  // page_count[5:0], start_page[10:6]
    input  wire logic [0:0]                        s_tuser,  // opcode[0]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [bpra_pkg::M_TDATA_W-1:0]         m_tdata   // status[1:0], first_page[6:2]
);

    bpra_pkg::dp_cmd_t               cmd;
    bpra_pkg::dp_status_t            stat;
    logic [bpra_pkg::STATUS_W-1:0]   out_status;
    logic [bpra_pkg::FIRST_W-1:0]    out_first;

    bpra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bpra_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .req_op     (s_tuser[0]),
        .req_count  (s_tdata[bpra_pkg::CNT_W-1:0]),
        .req_start  (s_tdata[bpra_pkg::CNT_W +: bpra_pkg::START_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_first  (out_first)
    );

    assign m_tdata = bpra_pkg::M_TDATA_W'({out_first, out_status});

endmodule

`default_nettype wire

/* tb/bitmap_page_run_allocator_tb.sv */
// ---------------------------------------------------------------------------
// bitmap_page_run_allocator_tb
// Self-checking regression of the first-fit page run allocator.
//
// A table of directed requests covers the error codes, full and empty
// bitmaps, runs clipped at the last page and frees of free pages. Random
// allocate/free traffic follows. Every result item is compared against a
// typed table row or a bitmap model in the testbench, with random idling
// on both sides, a long receiver hold-off and a sender pause that drains the results.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module bitmap_page_run_allocator_tb;

    localparam int RANDOM_ITEMS = 750;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_AT      = 4000;
    localparam int HOLD_LEN     = 400;
    localparam int RX_CALM_FROM = 8000;
    localparam int RX_CALM_TO   = 11000;

    typedef struct packed {
        logic [bpra_pkg::STATUS_W-1:0] status;
        logic [bpra_pkg::FIRST_W-1:0]  first_page;
    } page_result_t;

    typedef struct packed {
        logic                          op;
        logic [bpra_pkg::CNT_W-1:0]    page_count;
        logic [bpra_pkg::START_W-1:0]  start_page;
        logic                          typed;
        logic [bpra_pkg::STATUS_W-1:0] status;
        logic [bpra_pkg::FIRST_W-1:0]  first_page;
    } plan_row_t;

    localparam int PLAN_LEN = 26;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{bpra_pkg::OP_ALLOC, 6'd0,  5'd0,  1'b1, bpra_pkg::ST_ZERO_COUNT, 5'd0},
        '{bpra_pkg::OP_ALLOC, 6'd33, 5'd0,  1'b1, bpra_pkg::ST_NO_SPACE,   5'd0},
        '{bpra_pkg::OP_ALLOC, 6'd63, 5'd31, 1'b1, bpra_pkg::ST_NO_SPACE,   5'd0},
        '{bpra_pkg::OP_ALLOC, 6'd32, 5'd31, 1'b1, bpra_pkg::ST_OK,         5'd0},
        '{bpra_pkg::OP_ALLOC, 6'd1,  5'd0,  1'b1, bpra_pkg::ST_NO_SPACE,   5'd0},
        '{bpra_pkg::OP_FREE,  6'd63, 5'd31, 1'b1, bpra_pkg::ST_OK,         5'd0},
        '{bpra_pkg::OP_ALLOC, 6'd1,  5'd0,  1'b1, bpra_pkg::ST_OK,         5'd31},
        '{bpra_pkg::OP_FREE,  6'd0,  5'd5,  1'b1, bpra_pkg::ST_OK,         5'd0},
        '{bpra_pkg::OP_ALLOC, 6'd1,  5'd0,  1'b1, bpra_pkg::ST_NO_SPACE,   5'd0},
        '{bpra_pkg::OP_FREE,  6'd32, 5'd0,  1'b1, bpra_pkg::ST_OK,         5'd0},
        '{bpra_pkg::OP_FREE,  6'd5,  5'd3,  1'b1, bpra_pkg::ST_OK,         5'd0},
        '{bpra_pkg::OP_ALLOC, 6'd1,  5'd21, 1'b1, bpra_pkg::ST_OK,         5'd0},
        '{bpra_pkg::OP_ALLOC, 6'd3,  5'd0,  1'b0, bpra_pkg::ST_OK,         5'd0},
        '{bpra_pkg::OP_FREE,  6'd1,  5'd1,  1'b0, bpra_pkg::ST_OK,         5'd0},
        '{bpra_pkg::OP_ALLOC, 6'd2,  5'd0,  1'b0, bpra_pkg::ST_OK,         5'd0},
        '{bpra_pkg::OP_ALLOC, 6'd1,  5'd0,  1'b0, bpra_pkg::ST_OK,         5'd0},
        '{bpra_pkg::OP_FREE,  6'd31, 5'd1,  1'b0, bpra_pkg::ST_OK,         5'd0},
        '{bpra_pkg::OP_ALLOC, 6'd31, 5'd0,  1'b0, bpra_pkg::ST_OK,         5'd0},
        '{bpra_pkg::OP_FREE,  6'd32, 5'd31, 1'b0, bpra_pkg::ST_OK,         5'd0},
        '{bpra_pkg::OP_FREE,  6'd63, 5'd0,  1'b1, bpra_pkg::ST_OK,         5'd0},
        '{bpra_pkg::OP_ALLOC, 6'd16, 5'd31, 1'b0, bpra_pkg::ST_OK,         5'd0},
        '{bpra_pkg::OP_ALLOC, 6'd16, 5'd10, 1'b0, bpra_pkg::ST_OK,         5'd0},
        '{bpra_pkg::OP_ALLOC, 6'd1,  5'd0,  1'b1, bpra_pkg::ST_NO_SPACE,   5'd0},
        '{bpra_pkg::OP_FREE,  6'd6,  5'd10, 1'b0, bpra_pkg::ST_OK,         5'd0},
        '{bpra_pkg::OP_ALLOC, 6'd6,  5'd0,  1'b0, bpra_pkg::ST_OK,         5'd0},
        '{bpra_pkg::OP_FREE,  6'd63, 5'd0,  1'b1, bpra_pkg::ST_OK,         5'd0}
    };

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [bpra_pkg::S_TDATA_W-1:0] s_tdata  = '0;   // page_count[5:0], start_page[10:6]
    logic [0:0]                     s_tuser  = '0;   // opcode[0]
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [bpra_pkg::M_TDATA_W-1:0] m_tdata;         // status[1:0], first_page[6:2]

    logic [bpra_pkg::NUM_PAGES-1:0] page_map = '0;
    page_result_t                   pending_results [$];
    int                             mismatches = 0;
    int                             quiet_cycles = 0;
    bit                             tx_calm = 1'b0;

    bitmap_page_run_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic page_result_t apply_request(
        input logic                         op,
        input logic [bpra_pkg::CNT_W-1:0]   cnt,
        input logic [bpra_pkg::START_W-1:0] start
    );
        page_result_t res;
        int           run;
        int           first;
        bit           found;
        res.status     = bpra_pkg::ST_OK;
        res.first_page = '0;
        run   = 0;
        first = 0;
        found = 1'b0;
        if (op == bpra_pkg::OP_ALLOC) begin
            if (cnt == 0) begin
                res.status = bpra_pkg::ST_ZERO_COUNT;
            end else begin
                for (int p = 0; p < bpra_pkg::NUM_PAGES && !found; p++) begin
                    if (page_map[p]) begin
                        run = 0;
                    end else begin
                        run++;
                        if (run == int'(cnt)) begin
                            found = 1'b1;
                            first = p + 1 - int'(cnt);
                        end
                    end
                end
                if (found) begin
                    for (int p = first; p < first + int'(cnt); p++) page_map[p] = 1'b1;
                    res.first_page = bpra_pkg::FIRST_W'(first);
                end else begin
                    res.status = bpra_pkg::ST_NO_SPACE;
                end
            end
        end else begin
            for (int p = int'(start);
                 p < int'(start) + int'(cnt) && p < bpra_pkg::NUM_PAGES; p++)
                page_map[p] = 1'b0;
        end
        return res;
    endfunction

    task automatic offer_request(
        input logic                         op,
        input logic [bpra_pkg::CNT_W-1:0]   cnt,
        input logic [bpra_pkg::START_W-1:0] start,
        input bit                           typed,
        input page_result_t                 typed_res
    );
        page_result_t res;
        while (!tx_calm && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= bpra_pkg::S_TDATA_W'({start, cnt});
        do @(negedge aclk); while (!s_tready);
        res = apply_request(op, cnt, start);
        pending_results.push_back(typed ? typed_res : res);
        @(posedge aclk);
    endtask

    initial begin : stimulus
        page_result_t               typed_res;
        logic                       op;
        logic [bpra_pkg::CNT_W-1:0] cnt;
        int                         roll;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < PLAN_LEN; i++) begin
            typed_res.status     = PLAN[i].status;
            typed_res.first_page = PLAN[i].first_page;
            offer_request(PLAN[i].op, PLAN[i].page_count, PLAN[i].start_page,
                          PLAN[i].typed, typed_res);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 300) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pending_results.size() != 0);
            end
            tx_calm = (i >= 400 && i < 550);
            op   = ($urandom_range(99) < 55) ? bpra_pkg::OP_ALLOC : bpra_pkg::OP_FREE;
            roll = $urandom_range(99);
            if (op == bpra_pkg::OP_ALLOC) begin
                if (roll < 8)       cnt = '0;
                else if (roll < 14) cnt = bpra_pkg::CNT_W'($urandom_range(63, 33));
                else if (roll < 30) cnt = bpra_pkg::CNT_W'($urandom_range(32, 9));
                else                cnt = bpra_pkg::CNT_W'($urandom_range(8, 1));
            end else begin
                if (roll < 5)       cnt = '0;
                else if (roll < 15) cnt = bpra_pkg::CNT_W'($urandom_range(63, 13));
                else                cnt = bpra_pkg::CNT_W'($urandom_range(12, 1));
            end
            offer_request(op, cnt, bpra_pkg::START_W'($urandom_range(31, 0)), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (mismatches == 0) begin
            $display("bitmap_page_run_allocator regression: pass");
        end else begin
            $display("bitmap_page_run_allocator regression: fail");
        end
        $finish;
    end

    initial begin : result_sink
        int cycle;
        cycle = 0;
        forever begin
            @(posedge aclk);
            cycle++;
            if (cycle >= HOLD_AT && cycle < HOLD_AT + HOLD_LEN) begin
                m_tready <= 1'b0;
            end else if (cycle >= RX_CALM_FROM && cycle < RX_CALM_TO) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 19);
            end
        end
    end

    always @(negedge aclk) begin : check_results
        page_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item: status %0d first_page %0d",
                       m_tdata[1:0], m_tdata[6:2]);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tdata[1:0]);
                    mismatches++;
                end
                if (m_tdata[6:2] !== want.first_page) begin
                    $error("first_page: expected %0d, actual %0d",
                           want.first_page, m_tdata[6:2]);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("bitmap_page_run_allocator regression: fail");
                $finish;
            end
        end
    end

endmodule
